// ===== design/tcrd_pkg.sv =====
// ============================================================================
// tcrd_pkg
// Shared types and constants of the touch calibrate / release detect block.
// ============================================================================
`default_nettype none

package tcrd_pkg;

    // sample and field widths
    localparam int RAW_W   = 10;
    localparam int COEF_W  = 32;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int SCR_W   = 16;
    localparam int PRS_W   = 12;
    localparam int IDX_W   = 3;

    // press window and converter resolution
    localparam int SAMPLE_BITS  = 10;
    localparam int MIN_PRESSURE = 10;
    localparam int MAX_PRESSURE = 1000;
    localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // request queue between front and back (depth is a power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic {
        EV_DOWN = 1'b0,
        EV_UP   = 1'b1
    } t_ev_kind;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_XX       = 3'd0,
        REG_COEF_XY       = 3'd1,
        REG_OFFSET_X      = 3'd2,
        REG_COEF_YX       = 3'd3,
        REG_COEF_YY       = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_MIN_RES       = 3'd6,
        REG_RELEASE_DELAY = 3'd7
    } t_reg_idx;

    // one classified request: an event plus what the back end needs
    typedef struct packed {
        t_ev_kind                 kind;
        logic [RAW_W-1:0]         x;
        logic [RAW_W-1:0]         y;
        logic signed [PRS_W-1:0]  pressure;
    } t_cmd;

    // calibration coefficients, scaled by 10000
    typedef struct packed {
        logic signed [COEF_W-1:0] xx;
        logic signed [COEF_W-1:0] xy;
        logic signed [COEF_W-1:0] off_x;
        logic signed [COEF_W-1:0] yx;
        logic signed [COEF_W-1:0] yy;
        logic signed [COEF_W-1:0] off_y;
    } t_cal_cfg;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== design/tcrd_if.sv =====
// ============================================================================
// tcrd_if
// Valid/ready channels: raw touch samples in, touch events out.
// ============================================================================
`default_nettype none

interface tcrd_sample_if import tcrd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RAW_W-1:0]    raw_x;
    logic [RAW_W-1:0]    raw_y;
    logic [RAW_W-1:0]    raw_pressure;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, raw_x, raw_y, raw_pressure, now_ms, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_pressure, now_ms, output ready);
endinterface

interface tcrd_event_if import tcrd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     event_kind;
    logic signed [SCR_W-1:0]  screen_x;
    logic signed [SCR_W-1:0]  screen_y;
    logic signed [PRS_W-1:0]  pressure_out;

    modport source (output valid, event_kind, screen_x, screen_y, pressure_out,
                    input ready);
    modport sink   (input valid, event_kind, screen_x, screen_y, pressure_out,
                    output ready);
endinterface

`default_nettype wire

// ===== design/touch_calibrate_release_detect.sv =====
// ============================================================================
// touch_calibrate_release_detect
// Raw touch samples to calibrated down / up events.
// ============================================================================
// Usage:
//   i_sample (valid/ready) carries raw x, y, pressure and a millisecond time.
//   A sample with pressure strictly inside the press window produces a down
//   event with affine-calibrated, saturated screen coordinates and a pressure
//   value. A non-press sample while touching, once the release delay has
//   passed since the last press, produces an up event. Other samples produce
//   nothing.
//   o_event (valid/ready) carries the events in sample order.
//   The configuration port writes calibration coefficients, the minimum
//   resistance and the release delay; write only while the block is idle.
// Timing:
//   One sample per cycle sustained while the request queue is not full. After
//   its sample is accepted, an event passes through the request queue and then
//   the calibration pipeline stages in order (products, sum, magnitude,
//   reciprocal multiply, divisor multiply, correction into the output register).
//   When o_event stalls the pipeline holds; the four-entry request queue then
//   fills and i_sample.ready drops. Samples that make no event are accepted
//   regardless of how full the pipeline is, as long as the queue is not full.
// Reset: synchronous, active low; clears touch state, queue and pipeline, and
//   loads the identity calibration and a 100 ms release delay.
// ============================================================================
`default_nettype none

module touch_calibrate_release_detect import tcrd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [COEF_W-1:0]  i_cfg_data,
    tcrd_sample_if.sink             i_sample,
    tcrd_event_if.source            o_event
);

    localparam int UNITY = 10000;

    t_cal_cfg             r_cal;
    logic [RAW_W-1:0]     r_min_res;
    logic [DELAY_W-1:0]   r_delay;

    t_q_status            q_status;
    logic                 push;
    logic                 pop;
    t_cmd                 push_cmd;
    t_cmd                 head_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.xx    <= COEF_W'(UNITY);
            r_cal.xy    <= '0;
            r_cal.off_x <= '0;
            r_cal.yx    <= '0;
            r_cal.yy    <= COEF_W'(UNITY);
            r_cal.off_y <= '0;
            r_min_res   <= '0;
            r_delay     <= DELAY_W'(100);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_COEF_XX:       r_cal.xx    <= i_cfg_data;
                REG_COEF_XY:       r_cal.xy    <= i_cfg_data;
                REG_OFFSET_X:      r_cal.off_x <= i_cfg_data;
                REG_COEF_YX:       r_cal.yx    <= i_cfg_data;
                REG_COEF_YY:       r_cal.yy    <= i_cfg_data;
                REG_OFFSET_Y:      r_cal.off_y <= i_cfg_data;
                REG_MIN_RES:       r_min_res   <= i_cfg_data[RAW_W-1:0];
                REG_RELEASE_DELAY: r_delay     <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    tcrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .i_min_res  (r_min_res),
        .i_delay    (r_delay),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tcrd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    tcrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cal      (r_cal),
        .i_q_status (q_status),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_event    (o_event)
    );

endmodule

`default_nettype wire

// ===== design/tcrd_front.sv =====
// ============================================================================
// tcrd_front
// Accepts samples, classifies press / release / nothing, keeps touch state
// and queues one request per event.
// ============================================================================
`default_nettype none

module tcrd_front import tcrd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tcrd_sample_if.sink               i_sample,
    input  wire logic [RAW_W-1:0]     i_min_res,
    input  wire logic [DELAY_W-1:0]   i_delay,
    input  wire t_q_status            i_q_status,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    localparam int P_W = PRS_W + 2;
    localparam int PRS_MAX = (1 << (PRS_W - 1)) - 1;
    localparam int PRS_MIN = -(1 << (PRS_W - 1));

    logic                r_touching;
    logic [TIME_W-1:0]   r_last_ms;

    logic                accept;
    logic                press;
    logic                release_up;
    logic [RAW_W-1:0]    sx;
    logic [RAW_W-1:0]    sy;
    logic [RAW_W-1:0]    sz;
    logic [TIME_W-1:0]   elapsed;
    logic signed [P_W-1:0]   p_full;
    logic signed [PRS_W-1:0] p_sat;

    assign i_sample.ready = !i_q_status.full;
    assign accept = i_sample.valid && i_sample.ready;

    // classify the sample
    always_comb begin
        sx      = i_sample.raw_x & SAMPLE_MASK;
        sy      = i_sample.raw_y & SAMPLE_MASK;
        sz      = i_sample.raw_pressure & SAMPLE_MASK;
        elapsed = i_sample.now_ms - r_last_ms;
        press   = (sz > RAW_W'(MIN_PRESSURE)) && (sz < RAW_W'(MAX_PRESSURE));
        release_up = !press && r_touching && (elapsed >= TIME_W'(i_delay));
    end

    // pressure value, clamped to the output range
    always_comb begin
        p_full = P_W'(MAX_PRESSURE) - $signed(P_W'(sz)) + $signed(P_W'(i_min_res));
        if (p_full > P_W'(PRS_MAX)) begin
            p_sat = PRS_W'(PRS_MAX);
        end else if (p_full < P_W'(PRS_MIN)) begin
            p_sat = PRS_W'(PRS_MIN);
        end else begin
            p_sat = PRS_W'(p_full);
        end
    end

    // queued request
    always_comb begin
        o_push        = accept && (press || release_up);
        o_cmd.kind    = press ? EV_DOWN : EV_UP;
        o_cmd.x       = sx;
        o_cmd.y       = sy;
        o_cmd.pressure = press ? p_sat : '0;
    end

    // touch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching <= 1'b0;
            r_last_ms  <= '0;
        end else if (accept) begin
            if (press) begin
                r_touching <= 1'b1;
                r_last_ms  <= i_sample.now_ms;
            end else if (release_up) begin
                r_touching <= 1'b0;
            end
        end
    end

    a_press_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && press) |=> (r_touching && r_last_ms == $past(i_sample.now_ms)))
        else $error("press did not record its time");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.kind == EV_UP) |=> !r_touching)
        else $error("release did not clear touching");

endmodule

`default_nettype wire

// ===== design/tcrd_fifo.sv =====
// ============================================================================
// tcrd_fifo
// Short request queue between the classifier and the calibration pipeline.
// ============================================================================
`default_nettype none

module tcrd_fifo import tcrd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_cmd   i_cmd,
    input  wire logic   i_pop,
    output t_cmd        o_cmd,
    output t_q_status   o_status
);

    t_cmd                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp;
    logic [FIFO_AW-1:0]  r_rp;
    logic [FIFO_AW:0]    r_cnt;

    assign o_cmd           = r_mem[r_rp];
    assign o_status.full   = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_status.empty  = (r_cnt == '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== design/tcrd_back.sv =====
// ============================================================================
// tcrd_back
// Calibration pipeline: affine sum, rounding, divide by 10000 and saturation,
// with the output register at its end.
// ============================================================================
`default_nettype none

module tcrd_back import tcrd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cal_cfg    i_cal,
    input  wire t_q_status   i_q_status,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    tcrd_event_if.source     o_event
);

    localparam int NST        = 6;
    localparam int LANES      = 2;
    localparam int PROD_W     = COEF_W + RAW_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SCALE_DIV  = 10000;
    localparam int SCALE_HALF = 5000;
    localparam int SAT_LIMIT  = (1 << (SCR_W - 1)) * SCALE_DIV;
    localparam int MAG_W      = $clog2(SAT_LIMIT);
    localparam int RECIP_SH   = MAG_W;
    localparam int RECIP      = (1 << RECIP_SH) / SCALE_DIV;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int MP_W       = MAG_W + RECIP_W;
    localparam int Q_W        = MP_W - RECIP_SH;
    localparam int SCR_MAX    = (1 << (SCR_W - 1)) - 1;
    localparam int SCR_MIN    = -(1 << (SCR_W - 1));

    logic en;

    // stage valids and per-request metadata
    logic                     r_v    [NST];
    t_ev_kind                 r_kind [NST];
    logic signed [PRS_W-1:0]  r_prs  [NST];

    // per-lane coefficients (lane 0 = x, lane 1 = y)
    logic signed [COEF_W-1:0] coef_a [LANES];
    logic signed [COEF_W-1:0] coef_b [LANES];
    logic signed [COEF_W-1:0] coef_c [LANES];

    logic signed [PROD_W-1:0] r_pa  [LANES];
    logic signed [PROD_W-1:0] r_pb  [LANES];
    logic signed [SUM_W-1:0]  r_sum [LANES];
    logic [SUM_W-1:0]         n_mag [LANES];
    logic                     r_neg3 [LANES];
    logic                     r_sat3 [LANES];
    logic [MAG_W-1:0]         r_mag3 [LANES];
    logic [MP_W-1:0]          n_mp   [LANES];
    logic                     r_neg4 [LANES];
    logic                     r_sat4 [LANES];
    logic [MAG_W-1:0]         r_mag4 [LANES];
    logic [Q_W-1:0]           r_q4   [LANES];
    logic                     r_neg5 [LANES];
    logic                     r_sat5 [LANES];
    logic [MAG_W-1:0]         r_mag5 [LANES];
    logic [Q_W-1:0]           r_q5   [LANES];
    logic [MAG_W-1:0]         r_qm5  [LANES];
    logic [MAG_W-1:0]         n_rem  [LANES];
    logic [Q_W-1:0]           n_q    [LANES];
    logic signed [SCR_W-1:0]  n_scr  [LANES];
    logic signed [SCR_W-1:0]  r_scr  [LANES];

    // whole pipeline advances while the output register can move
    assign en    = !r_v[NST-1] || o_event.ready;
    assign o_pop = en && !i_q_status.empty;

    always_comb begin
        coef_a[0] = i_cal.xx;
        coef_b[0] = i_cal.xy;
        coef_c[0] = i_cal.off_x;
        coef_a[1] = i_cal.yx;
        coef_b[1] = i_cal.yy;
        coef_c[1] = i_cal.off_y;
    end

    // magnitude, reciprocal product and final correction per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_mag[l] = r_sum[l][SUM_W-1] ? SUM_W'(-r_sum[l]) : SUM_W'(r_sum[l]);
            n_mp[l]  = MP_W'(r_mag3[l]) * MP_W'(RECIP);
            n_rem[l] = r_mag5[l] - r_qm5[l];
            n_q[l]   = r_q5[l] + Q_W'(n_rem[l] >= MAG_W'(SCALE_DIV));
            if (r_sat5[l]) begin
                n_scr[l] = r_neg5[l] ? SCR_W'(SCR_MIN) : SCR_W'(SCR_MAX);
            end else if (r_neg5[l]) begin
                n_scr[l] = -$signed(SCR_W'(n_q[l]));
            end else begin
                n_scr[l] = $signed(SCR_W'(n_q[l]));
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= !i_q_status.empty;
            for (int s = 1; s < NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind[0] <= i_cmd.kind;
            r_prs[0]  <= i_cmd.pressure;
            for (int s = 1; s < NST; s++) begin
                r_kind[s] <= r_kind[s-1];
                r_prs[s]  <= r_prs[s-1];
            end
            for (int l = 0; l < LANES; l++) begin
                // products of weight and raw coordinate
                r_pa[l] <= PROD_W'(coef_a[l]) * $signed(PROD_W'(i_cmd.x));
                r_pb[l] <= PROD_W'(coef_b[l]) * $signed(PROD_W'(i_cmd.y));
                // affine sum with rounding offset
                r_sum[l] <= SUM_W'(r_pa[l]) + SUM_W'(r_pb[l]) + SUM_W'(coef_c[l])
                            + SUM_W'(SCALE_HALF);
                // sign, saturation, magnitude
                r_neg3[l] <= r_sum[l][SUM_W-1];
                r_sat3[l] <= n_mag[l] >= SUM_W'(SAT_LIMIT);
                r_mag3[l] <= n_mag[l][MAG_W-1:0];
                // quotient estimate, low by at most one
                r_neg4[l] <= r_neg3[l];
                r_sat4[l] <= r_sat3[l];
                r_mag4[l] <= r_mag3[l];
                r_q4[l]   <= n_mp[l][MP_W-1:RECIP_SH];
                // estimate times divisor
                r_neg5[l] <= r_neg4[l];
                r_sat5[l] <= r_sat4[l];
                r_mag5[l] <= r_mag4[l];
                r_q5[l]   <= r_q4[l];
                r_qm5[l]  <= MAG_W'(r_q4[l]) * MAG_W'(SCALE_DIV);
                // corrected, signed, saturated result; zero for release events
                r_scr[l]  <= (r_kind[NST-2] == EV_UP) ? '0 : n_scr[l];
            end
        end
    end

    assign o_event.valid        = r_v[NST-1];
    assign o_event.event_kind   = r_kind[NST-1];
    assign o_event.screen_x     = r_scr[0];
    assign o_event.screen_y     = r_scr[1];
    assign o_event.pressure_out = r_prs[NST-1];

    a_up_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.event_kind == EV_UP) |->
        (o_event.screen_x == '0 && o_event.screen_y == '0 && o_event.pressure_out == '0))
        else $error("release event with nonzero fields");

endmodule

`default_nettype wire
